[src/cbct_pkg.sv]
`default_nettype none

package cbct_pkg;

    localparam int COUNT_W = 23;
    localparam int SUM_W   = 34;
    localparam int POS_W   = 11;
    localparam int CHAN_W  = 8;
    localparam int DIM_W   = 12;

    localparam int AREA_LIMIT   = 10000;
    localparam int PIXEL_WEIGHT = 255;
    localparam logic [COUNT_W-1:0] MIN_COUNT = COUNT_W'(AREA_LIMIT / PIXEL_WEIGHT + 1);
    localparam logic [DIM_W-1:0]   EDGE_MARGIN = DIM_W'(15);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_HIGH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd7;

    localparam logic [CHAN_W-1:0] RST_HUE_LOW      = 8'd170;
    localparam logic [CHAN_W-1:0] RST_HUE_HIGH     = 8'd179;
    localparam logic [CHAN_W-1:0] RST_SAT_LOW      = 8'd150;
    localparam logic [CHAN_W-1:0] RST_SAT_HIGH     = 8'd255;
    localparam logic [CHAN_W-1:0] RST_VAL_LOW      = 8'd60;
    localparam logic [CHAN_W-1:0] RST_VAL_HIGH     = 8'd255;
    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 12'd1280;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 12'd720;

    typedef struct packed {
        logic [CHAN_W-1:0] hue_low;
        logic [CHAN_W-1:0] hue_high;
        logic [CHAN_W-1:0] sat_low;
        logic [CHAN_W-1:0] sat_high;
        logic [CHAN_W-1:0] val_low;
        logic [CHAN_W-1:0] val_high;
    } bounds_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   col_sum;
        logic [SUM_W-1:0]   row_sum;
    } totals_t;

    typedef struct packed {
        logic             object_found;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             exit_left;
        logic             exit_right;
        logic             exit_top;
        logic             exit_bottom;
    } result_t;

endpackage

`default_nettype wire

[src/cbct_fifo.sv]
`default_nettype none

module cbct_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[src/cbct_front.sv]
`default_nettype none

module cbct_front
    import cbct_pkg::*;
#(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 2048
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bounds_t           bounds,
    input  wire logic              accept,
    input  wire logic [CHAN_W-1:0] hue,
    input  wire logic [CHAN_W-1:0] saturation,
    input  wire logic [CHAN_W-1:0] brightness,
    input  wire logic [POS_W-1:0]  col,
    input  wire logic [POS_W-1:0]  row,
    input  wire logic              end_of_frame,
    output totals_t                totals,
    output logic                   frame_push
);

    localparam logic [POS_W+1:0] COL_LIMIT = (POS_W + 2)'(MAX_COLS);
    localparam logic [POS_W+1:0] ROW_LIMIT = (POS_W + 2)'(MAX_ROWS);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0]   col_sum_reg, col_sum_next;
    logic [SUM_W-1:0]   row_sum_reg, row_sum_next;
    logic               hit;

    assign hit = (hue >= bounds.hue_low) && (hue <= bounds.hue_high)
              && (saturation >= bounds.sat_low) && (saturation <= bounds.sat_high)
              && (brightness >= bounds.val_low) && (brightness <= bounds.val_high)
              && ({2'b00, col} < COL_LIMIT) && ({2'b00, row} < ROW_LIMIT);

    // running totals including the current pixel
    assign totals.count   = hit ? count_reg + 1'b1 : count_reg;
    assign totals.col_sum = hit ? col_sum_reg + SUM_W'(col) : col_sum_reg;
    assign totals.row_sum = hit ? row_sum_reg + SUM_W'(row) : row_sum_reg;
    assign frame_push     = accept && end_of_frame;

    always_comb
    begin
        count_next   = count_reg;
        col_sum_next = col_sum_reg;
        row_sum_next = row_sum_reg;
        if (accept)
        begin
            if (end_of_frame)
            begin
                count_next   = '0;
                col_sum_next = '0;
                row_sum_next = '0;
            end
            else
            begin
                count_next   = totals.count;
                col_sum_next = totals.col_sum;
                row_sum_next = totals.row_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            col_sum_reg <= '0;
            row_sum_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            col_sum_reg <= col_sum_next;
            row_sum_reg <= row_sum_next;
        end
    end

endmodule

`default_nettype wire

[src/cbct_back.sv]
`default_nettype none

module cbct_back
    import cbct_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [DIM_W-1:0] frame_width,
    input  wire logic [DIM_W-1:0] frame_height,
    input  wire totals_t          totals,
    input  wire logic             totals_empty,
    output logic                  totals_pop,
    output result_t               result,
    output logic                  result_push,
    input  wire logic             result_full
);

    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [COUNT_W-1:0] divisor_reg, divisor_next;
    logic [SUM_W-1:0]   col_dvd_reg, col_dvd_next;
    logic [SUM_W-1:0]   row_dvd_reg, row_dvd_next;
    logic [COUNT_W-1:0] col_rem_reg, col_rem_next;
    logic [COUNT_W-1:0] row_rem_reg, row_rem_next;
    logic [POS_W-1:0]   col_quo_reg, col_quo_next;
    logic [POS_W-1:0]   row_quo_reg, row_quo_next;
    logic               found_reg, found_next;
    logic               prev_valid_reg, prev_valid_next;
    logic [POS_W-1:0]   prev_x_reg, prev_x_next;
    logic [POS_W-1:0]   prev_y_reg, prev_y_next;

    logic [COUNT_W:0]   col_trial, row_trial;
    logic [COUNT_W:0]   col_diff, row_diff;
    logic               col_ge, row_ge;

    // one restoring step for each sum, shared divisor
    assign col_trial = {col_rem_reg, col_dvd_reg[SUM_W-1]};
    assign row_trial = {row_rem_reg, row_dvd_reg[SUM_W-1]};
    assign col_ge    = col_trial >= {1'b0, divisor_reg};
    assign row_ge    = row_trial >= {1'b0, divisor_reg};
    assign col_diff  = col_trial - {1'b0, divisor_reg};
    assign row_diff  = row_trial - {1'b0, divisor_reg};

    assign totals_pop  = (state_reg == S_IDLE) && !totals_empty;
    assign result_push = (state_reg == S_PUSH) && !result_full;

    always_comb
    begin
        result.object_found = found_reg;
        result.pos_x        = col_quo_reg;
        result.pos_y        = row_quo_reg;
        result.exit_left    = found_reg && prev_valid_reg
                           && ({1'b0, col_quo_reg} <= EDGE_MARGIN)
                           && (col_quo_reg < prev_x_reg);
        result.exit_right   = found_reg && prev_valid_reg
                           && (({1'b0, col_quo_reg} + EDGE_MARGIN) >= frame_width)
                           && (col_quo_reg > prev_x_reg);
        result.exit_top     = found_reg && prev_valid_reg
                           && ({1'b0, row_quo_reg} <= EDGE_MARGIN)
                           && (row_quo_reg < prev_y_reg);
        result.exit_bottom  = found_reg && prev_valid_reg
                           && (({1'b0, row_quo_reg} + EDGE_MARGIN) >= frame_height)
                           && (row_quo_reg > prev_y_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        divisor_next    = divisor_reg;
        col_dvd_next    = col_dvd_reg;
        row_dvd_next    = row_dvd_reg;
        col_rem_next    = col_rem_reg;
        row_rem_next    = row_rem_reg;
        col_quo_next    = col_quo_reg;
        row_quo_next    = row_quo_reg;
        found_next      = found_reg;
        prev_valid_next = prev_valid_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!totals_empty)
                begin
                    step_next    = STEP_W'(SUM_W - 1);
                    divisor_next = totals.count;
                    col_dvd_next = totals.col_sum;
                    row_dvd_next = totals.row_sum;
                    col_rem_next = '0;
                    row_rem_next = '0;
                    col_quo_next = '0;
                    row_quo_next = '0;
                    found_next   = totals.count >= MIN_COUNT;
                    state_next   = (totals.count >= MIN_COUNT) ? S_DIV : S_PUSH;
                end
            end
            S_DIV:
            begin
                col_rem_next = col_ge ? col_diff[COUNT_W-1:0] : col_trial[COUNT_W-1:0];
                row_rem_next = row_ge ? row_diff[COUNT_W-1:0] : row_trial[COUNT_W-1:0];
                col_quo_next = {col_quo_reg[POS_W-2:0], col_ge};
                row_quo_next = {row_quo_reg[POS_W-2:0], row_ge};
                col_dvd_next = {col_dvd_reg[SUM_W-2:0], 1'b0};
                row_dvd_next = {row_dvd_reg[SUM_W-2:0], 1'b0};
                step_next    = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!result_full)
                begin
                    if (found_reg)
                    begin
                        prev_valid_next = 1'b1;
                        prev_x_next     = col_quo_reg;
                        prev_y_next     = row_quo_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            found_reg      <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            found_reg      <= found_next;
            prev_valid_reg <= prev_valid_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg    <= step_next;
        divisor_reg <= divisor_next;
        col_dvd_reg <= col_dvd_next;
        row_dvd_reg <= row_dvd_next;
        col_rem_reg <= col_rem_next;
        row_rem_reg <= row_rem_next;
        col_quo_reg <= col_quo_next;
        row_quo_reg <= row_quo_next;
    end

endmodule

`default_nettype wire

[src/color_blob_centroid_tracker.sv]
// pixels: one request per cycle, full rises only when four frame totals wait for the back end
// frame result: when the object is found, the position comes from the
// 34-step bit-serial divider (one quotient bit per cycle for column and row in parallel);
// when it is not found the divider is skipped; a found frame holds the divider until its result is pushed
// frames that end faster than the back end clears them back up into the totals queue and can raise full
// reset: bounds and frame size to defaults, sums cleared, no previous centroid, queues empty
`default_nettype none

module color_blob_centroid_tracker
    import cbct_pkg::*;
#(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 2048
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [CHAN_W-1:0]     hue,
    input  wire logic [CHAN_W-1:0]     saturation,
    input  wire logic [CHAN_W-1:0]     brightness,
    input  wire logic [POS_W-1:0]      col,
    input  wire logic [POS_W-1:0]      row,
    input  wire logic                  end_of_frame,
    output logic                       empty,
    input  wire logic                  pop,
    output logic                       object_found,
    output logic [POS_W-1:0]           pos_x,
    output logic [POS_W-1:0]           pos_y,
    output logic                       exit_left,
    output logic                       exit_right,
    output logic                       exit_top,
    output logic                       exit_bottom
);

    localparam int TOTALS_DEPTH = 4;
    localparam int RESULT_DEPTH = 2;

    logic [CHAN_W-1:0] hue_low_reg, hue_high_reg;
    logic [CHAN_W-1:0] sat_low_reg, sat_high_reg;
    logic [CHAN_W-1:0] val_low_reg, val_high_reg;
    logic [DIM_W-1:0]  frame_width_reg, frame_height_reg;

    bounds_t bounds;
    totals_t front_totals, queued_totals;
    result_t back_result, head_result;
    logic    frame_push, totals_empty, totals_pop;
    logic    result_push, result_full;
    logic    accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_low_reg      <= RST_HUE_LOW;
            hue_high_reg     <= RST_HUE_HIGH;
            sat_low_reg      <= RST_SAT_LOW;
            sat_high_reg     <= RST_SAT_HIGH;
            val_low_reg      <= RST_VAL_LOW;
            val_high_reg     <= RST_VAL_HIGH;
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_HUE_LOW:      hue_low_reg      <= cfg_data[CHAN_W-1:0];
                REG_HUE_HIGH:     hue_high_reg     <= cfg_data[CHAN_W-1:0];
                REG_SAT_LOW:      sat_low_reg      <= cfg_data[CHAN_W-1:0];
                REG_SAT_HIGH:     sat_high_reg     <= cfg_data[CHAN_W-1:0];
                REG_VAL_LOW:      val_low_reg      <= cfg_data[CHAN_W-1:0];
                REG_VAL_HIGH:     val_high_reg     <= cfg_data[CHAN_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign bounds.hue_low  = hue_low_reg;
    assign bounds.hue_high = hue_high_reg;
    assign bounds.sat_low  = sat_low_reg;
    assign bounds.sat_high = sat_high_reg;
    assign bounds.val_low  = val_low_reg;
    assign bounds.val_high = val_high_reg;

    assign accept = push && !full;

    cbct_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .bounds       (bounds),
        .accept       (accept),
        .hue          (hue),
        .saturation   (saturation),
        .brightness   (brightness),
        .col          (col),
        .row          (row),
        .end_of_frame (end_of_frame),
        .totals       (front_totals),
        .frame_push   (frame_push)
    );

    cbct_fifo #(
        .WIDTH ($bits(totals_t)),
        .DEPTH (TOTALS_DEPTH)
    ) u_totals_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (frame_push),
        .wdata (front_totals),
        .full  (full),
        .pop   (totals_pop),
        .rdata (queued_totals),
        .empty (totals_empty)
    );

    cbct_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .totals       (queued_totals),
        .totals_empty (totals_empty),
        .totals_pop   (totals_pop),
        .result       (back_result),
        .result_push  (result_push),
        .result_full  (result_full)
    );

    cbct_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (result_push),
        .wdata (back_result),
        .full  (result_full),
        .pop   (pop),
        .rdata (head_result),
        .empty (empty)
    );

    assign object_found = head_result.object_found;
    assign pos_x        = head_result.pos_x;
    assign pos_y        = head_result.pos_y;
    assign exit_left    = head_result.exit_left;
    assign exit_right   = head_result.exit_right;
    assign exit_top     = head_result.exit_top;
    assign exit_bottom  = head_result.exit_bottom;

endmodule

`default_nettype wire
